@@ sv/tsi_pkg.sv @@
// Package: types, widths and register codes of the timestamped sample interpolator.
`timescale 1ns / 1ps
`default_nettype none

package tsi_pkg;

   localparam int DEFAULT_HISTORY_DEPTH = 16;
   localparam int TIME_W     = 27;
   localparam int VAL_W      = 32;
   localparam int NUM_VALUES = 5;
   localparam int VALS_W     = VAL_W * NUM_VALUES;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int SRC_W      = 2;

   // product of |b - a| (32 bits) and |t - ta| (27 bits)
   localparam int PROD_W = VAL_W + TIME_W;
   // a plus signed quotient, enough headroom for the clamp
   localparam int SUM_W  = PROD_W + 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DEF_VELOCITY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_ALTITUDE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_HEADING   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_LATITUDE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_LONGITUDE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_WINDOW = 3'd5;

   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [SRC_W-1:0] SRC_DEFAULTS = 2'd0;
   localparam logic [SRC_W-1:0] SRC_SINGLE   = 2'd1;
   localparam logic [SRC_W-1:0] SRC_INTERP   = 2'd2;

   // reset values in slot order: velocity, altitude, heading, latitude, longitude
   localparam logic [VAL_W-1:0] DEFAULT_RESET [NUM_VALUES] = '{
      32'sd1310720, 32'sd2424832, 32'sd0, 32'sd2097152, -32'sd7667712
   };
   localparam logic [TIME_W-1:0] SEARCH_WINDOW_RESET = 27'd3600000;

   typedef struct packed {
      logic                     kind;
      logic        [TIME_W-1:0] sample_time;
      logic signed [VAL_W-1:0]  velocity;
      logic signed [VAL_W-1:0]  altitude;
      logic signed [VAL_W-1:0]  heading;
      logic signed [VAL_W-1:0]  latitude;
      logic signed [VAL_W-1:0]  longitude;
   } req_item_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] est_velocity;
      logic signed [VAL_W-1:0] est_altitude;
      logic signed [VAL_W-1:0] est_heading;
      logic signed [VAL_W-1:0] est_latitude;
      logic signed [VAL_W-1:0] est_longitude;
      logic        [SRC_W-1:0] estimate_source;
      logic                    saturated;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ sv/timestamped_sample_interpolator.sv @@
// Top level: timestamped sample history with nearest-sample lookup and interpolation.
`timescale 1ns / 1ps
`default_nettype none

// A store item (kind 0) advances the write pointer and the sample goes into the history
// RAMs at the new slot, no result. A query item (kind 1) scans every slot of the time RAM
// (one read a cycle), reads the two ring neighbors of the nearest hit, reads the value
// pair, then for each of the five values does one multiply and a bit-serial divide of
// PROD_W (59) steps. The query result falls back to defaults, copies one sample (also
// when the pair times are equal), or interpolates. busy is high for the whole query;
// rsp_valid is high for exactly one cycle with the result on rsp_item and cannot be
// held off, so take it then.
// Configuration writes through csr_* are meant for idle periods only.

module timestamped_sample_interpolator
   import tsi_pkg::*;
#(
   parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_item_type          req_item,
   output logic                       rsp_valid,
   output rsp_item_type               rsp_item,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(HISTORY_DEPTH - 1);
   localparam int VIDX_W = $clog2(NUM_VALUES);
   // clamp limits of the signed 32-bit result
   localparam logic signed [SUM_W-1:0] R_MAX = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] R_MIN = -SUM_W'(64'sd2147483648);

   typedef enum logic [11:0] {
      ST_IDLE = 12'b0000_0000_0001,
      ST_SCAN = 12'b0000_0000_0010,
      ST_NBRA = 12'b0000_0000_0100,
      ST_NBRB = 12'b0000_0000_1000,
      ST_PICK = 12'b0000_0001_0000,
      ST_VALA = 12'b0000_0010_0000,
      ST_VALB = 12'b0000_0100_0000,
      ST_MUL  = 12'b0000_1000_0000,
      ST_DIVS = 12'b0001_0000_0000,
      ST_DIV  = 12'b0010_0000_0000,
      ST_ACC  = 12'b0100_0000_0000,
      ST_SPARE = 12'b1000_0000_0000
   } state_type;

   // ---- configuration ----
   logic [VAL_W-1:0]  defaults_ff [NUM_VALUES];
   logic [TIME_W-1:0] window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VALUES; i++) begin
            defaults_ff[i] <= DEFAULT_RESET[i];
         end
         window_ff <= SEARCH_WINDOW_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_SEARCH_WINDOW) begin
            window_ff <= csr_wr_data[TIME_W-1:0];
         end else if (csr_index < CSR_SEARCH_WINDOW) begin
            defaults_ff[csr_index] <= csr_wr_data[VAL_W-1:0];
         end
      end
   end

   // ---- state ----
   state_type              state_ff, state_in;
   logic [HISTORY_DEPTH-1:0] valid_ff, valid_in;
   logic [AW-1:0]          wp_ff, wp_in;
   logic [CW-1:0]          scan_ff, scan_in;
   logic [TIME_W-1:0]      t_ff, t_in;
   logic [TIME_W-1:0]      best_dist_ff, best_dist_in;
   logic [AW-1:0]          best_ff, best_in;
   logic [TIME_W-1:0]      best_time_ff, best_time_in;
   logic                   found_ff, found_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic [TIME_W-1:0]      tn_ff, tn_in;
   logic [TIME_W-1:0]      ta_ff, ta_in, tb_ff, tb_in;
   logic [AW-1:0]          newer_ff, newer_in;
   logic                   single_ff, single_in;
   logic [VALS_W-1:0]      a_vals_ff, a_vals_in, b_vals_ff, b_vals_in;
   logic [VALS_W-1:0]      res_ff, res_in;
   logic [TIME_W-1:0]      dt_mag_ff, dt_mag_in, den_mag_ff, den_mag_in;
   logic                   dt_neg_ff, dt_neg_in, den_neg_ff, den_neg_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic                   neg_ff, neg_in;
   logic [VIDX_W-1:0]      v_ff, v_in;
   logic                   sat_ff, sat_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_item_type           rsp_item_ff, rsp_item_in;

   // ---- memories ----
   logic              accept, store;
   logic [AW-1:0]     wp_next;
   logic [AW-1:0]     time_rd_addr, val_rd_addr;
   logic [TIME_W-1:0] time_rd;
   logic [VALS_W-1:0] val_rd, req_vals;

   assign accept  = start && !busy;
   assign store   = accept && (req_item.kind == KIND_STORE);
   assign wp_next = (wp_ff == LAST) ? '0 : wp_ff + 1'b1;
   assign req_vals = {req_item.longitude, req_item.latitude, req_item.heading,
                      req_item.altitude, req_item.velocity};

   tsi_ram #(.WIDTH(TIME_W), .DEPTH(HISTORY_DEPTH), .ADDR_W(AW)) u_time_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (wp_next),
      .wr_data (req_item.sample_time),
      .rd_addr (time_rd_addr),
      .rd_data (time_rd)
   );

   tsi_ram #(.WIDTH(VALS_W), .DEPTH(HISTORY_DEPTH), .ADDR_W(AW)) u_val_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (wp_next),
      .wr_data (req_vals),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd)
   );

   // ---- divider ----
   logic              div_start, div_done;
   logic [PROD_W-1:0] quo;

   assign div_start = (state_ff == ST_DIVS);

   tsi_div #(.DIVIDEND_W(PROD_W), .DIVISOR_W(TIME_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_mag_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // ---- helpers ----
   function automatic logic [TIME_W-1:0] time_dist(input logic [TIME_W-1:0] x,
                                                   input logic [TIME_W-1:0] y);
      return (x >= y) ? x - y : y - x;
   endfunction

   logic [AW-1:0]     cmp_idx, nxt, prv, older_c, newer_c;
   logic [TIME_W-1:0] d_scan, dn, dp, ta_c, tb_c;
   logic              nv, pv, use_next;
   logic signed [VAL_W-1:0] a_cur, b_cur;
   logic signed [VAL_W:0]   ba_diff;
   logic [VAL_W-1:0]        ba_mag;
   logic signed [TIME_W:0]  dt_s, den_s;
   logic signed [SUM_W-1:0] q_s, r_s;
   logic [VAL_W-1:0]        r_clamped;
   logic                    r_sat;

   assign cmp_idx = AW'(scan_ff - 1'b1);
   assign d_scan  = time_dist(t_ff, time_rd);
   assign nxt     = (best_ff == LAST) ? '0 : best_ff + 1'b1;
   assign prv     = (best_ff == '0) ? LAST : best_ff - 1'b1;
   assign nv      = valid_ff[nxt] && cnt_ff[1];
   assign pv      = valid_ff[prv] && cnt_ff[1];
   assign dn      = time_dist(t_ff, tn_ff);
   assign dp      = time_dist(t_ff, time_rd);   // previous neighbor time arrives in ST_PICK
   assign use_next = nv && (!pv || dn <= dp);
   assign older_c = use_next ? best_ff : (pv ? prv : best_ff);
   assign newer_c = use_next ? nxt : best_ff;
   assign ta_c    = use_next ? best_time_ff : (pv ? time_rd : best_time_ff);
   assign tb_c    = use_next ? tn_ff : best_time_ff;

   assign a_cur   = a_vals_ff[VAL_W*v_ff +: VAL_W];
   assign b_cur   = b_vals_ff[VAL_W*v_ff +: VAL_W];
   assign ba_diff = {b_cur[VAL_W-1], b_cur} - {a_cur[VAL_W-1], a_cur};
   assign ba_mag  = ba_diff[VAL_W] ? VAL_W'(-ba_diff) : ba_diff[VAL_W-1:0];
   assign dt_s    = {1'b0, t_ff} - {1'b0, ta_ff};
   assign den_s   = {1'b0, tb_ff} - {1'b0, ta_ff};

   // signed quotient, then a + q, clamped to 32 bits
   assign q_s = neg_ff ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
   assign r_s = SUM_W'(a_cur) + q_s;
   always_comb begin
      r_sat     = 1'b0;
      r_clamped = r_s[VAL_W-1:0];
      if (r_s > R_MAX) begin
         r_clamped = {1'b0, {(VAL_W-1){1'b1}}};
         r_sat     = 1'b1;
      end else if (r_s < R_MIN) begin
         r_clamped = {1'b1, {(VAL_W-1){1'b0}}};
         r_sat     = 1'b1;
      end
   end

   function automatic rsp_item_type pack_rsp(input logic [VALS_W-1:0] vals,
                                             input logic [SRC_W-1:0]  src,
                                             input logic              sat);
      rsp_item_type r;
      r.est_velocity    = vals[0*VAL_W +: VAL_W];
      r.est_altitude    = vals[1*VAL_W +: VAL_W];
      r.est_heading     = vals[2*VAL_W +: VAL_W];
      r.est_latitude    = vals[3*VAL_W +: VAL_W];
      r.est_longitude   = vals[4*VAL_W +: VAL_W];
      r.estimate_source = src;
      r.saturated       = sat;
      return r;
   endfunction

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      wp_in        = wp_ff;
      scan_in      = scan_ff;
      t_in         = t_ff;
      best_dist_in = best_dist_ff;
      best_in      = best_ff;
      best_time_in = best_time_ff;
      found_in     = found_ff;
      cnt_in       = cnt_ff;
      tn_in        = tn_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      newer_in     = newer_ff;
      single_in    = single_ff;
      a_vals_in    = a_vals_ff;
      b_vals_in    = b_vals_ff;
      res_in       = res_ff;
      dt_mag_in    = dt_mag_ff;
      dt_neg_in    = dt_neg_ff;
      den_mag_in   = den_mag_ff;
      den_neg_in   = den_neg_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      v_in         = v_ff;
      sat_in       = sat_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      time_rd_addr = scan_ff[AW-1:0];
      val_rd_addr  = older_c;

      case (state_ff)
         ST_IDLE: begin
            if (store) begin
               wp_in             = wp_next;
               valid_in[wp_next] = 1'b1;
            end else if (accept) begin
               t_in         = req_item.sample_time;
               scan_in      = '0;
               best_dist_in = window_ff;
               found_in     = 1'b0;
               cnt_in       = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // slot scan_ff is read now; slot scan_ff - 1 is checked
            if (scan_ff != '0 && valid_ff[cmp_idx]) begin
               if (!cnt_ff[1]) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (d_scan < best_dist_ff) begin
                  best_dist_in = d_scan;
                  best_in      = cmp_idx;
                  best_time_in = time_rd;
                  found_in     = 1'b1;
               end
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == CW'(HISTORY_DEPTH)) begin
               state_in = ST_NBRA;
            end
         end
         ST_NBRA: begin
            if (!found_ff) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = pack_rsp({defaults_ff[4], defaults_ff[3], defaults_ff[2],
                                        defaults_ff[1], defaults_ff[0]}, SRC_DEFAULTS, 1'b0);
               state_in     = ST_IDLE;
            end else begin
               time_rd_addr = nxt;
               state_in     = ST_NBRB;
            end
         end
         ST_NBRB: begin
            time_rd_addr = prv;
            tn_in        = time_rd;
            state_in     = ST_PICK;
         end
         ST_PICK: begin
            val_rd_addr = older_c;
            ta_in       = ta_c;
            tb_in       = tb_c;
            newer_in    = newer_c;
            single_in   = !use_next && !pv;
            state_in    = ST_VALA;
         end
         ST_VALA: begin
            val_rd_addr = newer_ff;
            a_vals_in   = val_rd;
            state_in    = ST_VALB;
         end
         ST_VALB: begin
            b_vals_in = val_rd;
            if (single_ff) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = pack_rsp(a_vals_ff, SRC_SINGLE, 1'b0);
               state_in     = ST_IDLE;
            end else if (ta_ff == tb_ff) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = pack_rsp(a_vals_ff, SRC_INTERP, 1'b0);
               state_in     = ST_IDLE;
            end else begin
               dt_neg_in  = dt_s[TIME_W];
               dt_mag_in  = dt_s[TIME_W] ? TIME_W'(-dt_s) : dt_s[TIME_W-1:0];
               den_neg_in = den_s[TIME_W];
               den_mag_in = den_s[TIME_W] ? TIME_W'(-den_s) : den_s[TIME_W-1:0];
               v_in       = '0;
               sat_in     = 1'b0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(ba_mag) * PROD_W'(dt_mag_ff);
            neg_in   = ba_diff[VAL_W] ^ dt_neg_ff ^ den_neg_ff;
            state_in = ST_DIVS;
         end
         ST_DIVS: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            res_in[VAL_W*v_ff +: VAL_W] = r_clamped;
            sat_in = sat_ff | r_sat;
            if (v_ff == VIDX_W'(NUM_VALUES - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = pack_rsp(res_in, SRC_INTERP, sat_in);
               state_in     = ST_IDLE;
            end else begin
               v_in     = v_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff      <= scan_in;
      t_ff         <= t_in;
      best_dist_ff <= best_dist_in;
      best_ff      <= best_in;
      best_time_ff <= best_time_in;
      found_ff     <= found_in;
      cnt_ff       <= cnt_in;
      tn_ff        <= tn_in;
      ta_ff        <= ta_in;
      tb_ff        <= tb_in;
      newer_ff     <= newer_in;
      single_ff    <= single_in;
      a_vals_ff    <= a_vals_in;
      b_vals_ff    <= b_vals_in;
      res_ff       <= res_in;
      dt_mag_ff    <= dt_mag_in;
      dt_neg_ff    <= dt_neg_in;
      den_mag_ff   <= den_mag_in;
      den_neg_ff   <= den_neg_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      v_ff         <= v_in;
      sat_ff       <= sat_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---- checks ----
   a_rsp_after_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a query in flight");

   a_store_marks_valid: assert property (@(posedge clock) disable iff (reset)
      store |=> valid_ff[wp_ff])
      else $error("stored slot not marked valid");

   a_sat_only_interp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.estimate_source != SRC_INTERP) |-> !rsp_item.saturated)
      else $error("saturation flagged on a non-interpolated item");

   a_div_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the wait state");

endmodule

`default_nettype wire

@@ sv/tsi_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tsi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/tsi_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tsi_div #(
   parameter int DIVIDEND_W = 59,
   parameter int DIVISOR_W  = 27
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic      [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      cnt_ff,  cnt_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W-1:0]  rem_ff,  rem_in;
   logic [DIVIDEND_W-1:0] quo_ff,  quo_in;
   logic [DIVISOR_W:0]    trial;

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      if (start) begin
         cnt_in = CNT_W'(DIVIDEND_W);
         rem_in = '0;
         quo_in = dividend;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, divisor});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
